>>> rtl/dcct_pkg.sv
// Shared types and constants of the duty-cycle throttle.
// Used by dcct_ctrl, dcct_dp and duty_cycle_cpu_throttle; no dependencies.
`default_nettype none
package dcct_pkg;

   localparam int WINDOW_DEPTH_DEF = 10;

   localparam int TIME_W  = 48;
   localparam int TICK_W  = 32;
   localparam int WORK_W  = 20;
   localparam int LIM_W   = 7;
   localparam int HZ_W    = 14;
   localparam int Q16_W   = 17;
   localparam int SUM_W   = 26;   // holds up to 63 run times
   localparam int BUSY_W  = 52;
   localparam int SPAN_W  = 62;
   localparam int LH_W    = 21;
   localparam int NUM_W   = 47;
   localparam int DEN_W   = 59;
   localparam int WPROD_W = 67;
   localparam int DVD_W   = 68;
   localparam int DVS_W   = 62;
   localparam int QUO_W   = 21;   // every quotient here is below 2^21
   localparam int CNT_W   = 5;
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 27;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;
   localparam int CSR_A_W = 2;
   localparam int REQ_W   = 104;
   localparam int RSP_W   = 80;

   localparam logic [MUL_B_W-1:0] US_PER_S     = 27'd1000000;
   localparam logic [MUL_B_W-1:0] US_PER_S_PCT = 27'd100000000;
   localparam logic [Q16_W-1:0]   Q16_ONE      = 17'd65536;
   localparam logic [LIM_W-1:0]   PCT_FULL     = 7'd100;

   // floor(x / 100) = (x * RECIP_PCT) >> RECIP_SH for any x below 2^30
   localparam logic [MUL_B_W-1:0] RECIP_PCT = 27'd85899346;
   localparam int                 RECIP_SH  = 33;

   localparam logic [LIM_W-1:0]  LIMIT_RST  = 7'd100;
   localparam logic [WORK_W-1:0] PERIOD_RST = 20'd100000;
   localparam logic [HZ_W-1:0]   HZ_RST     = 14'd100;

   localparam logic [CSR_A_W-1:0] CSR_LIMIT     = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_PERIOD    = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_TICK_RATE = 2'd2;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_READ_OLD, OP_CAPTURE, OP_STEP, OP_ACCUM,
      OP_MUL_BUSY, OP_MUL_SPAN, OP_MUL_LH, OP_MUL_NUM, OP_MUL_DEN,
      OP_MUL_WORK, OP_MUL_FB, OP_FB_WORK, OP_FB_SHARE,
      OP_DIV_SHARE, OP_DIV_RATE, OP_DIV_WORK,
      OP_TAKE_SHARE, OP_TAKE_RATE, OP_TAKE_WORK,
      OP_SHARE_ONE, OP_RATE_ONE, OP_WORK_PER, OP_PUSH
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE, S_ROUTE, S_READ_OLD, S_CAPTURE, S_STEP, S_ACCUM, S_CHECK,
      S_MUL_BUSY, S_MUL_SPAN, S_MUL_LH, S_MUL_NUM, S_MUL_DEN,
      S_SHARE, S_SHARE_WAIT, S_RATE, S_RATE_WAIT,
      S_WORK, S_WORK_DIV, S_WORK_WAIT,
      S_FB_MUL, S_FB_WORK, S_FB_SHARE,
      S_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic first;       // window was empty or restarted
      logic at_newest;   // window walk reached the newest entry
      logic est_ok;      // elapsed time and run time both nonzero
      logic share_sat;
      logic rate_sat;
      logic work_per;    // slice is the full period
      logic div_busy;
      logic out_free;
   } status_type;

endpackage
`default_nettype wire

>>> rtl/dcct_ctrl.sv
// Sequencer of the duty-cycle throttle: steps the datapath through the window
// walk, products and divisions. Depends on dcct_pkg.
`default_nettype none
module dcct_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_tvalid,
   output logic                 req_tready,
   output dcct_pkg::cmd_type    cmd,
   input  dcct_pkg::status_type stat
);
   import dcct_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd.op     = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = OP_LOAD;
               state_in = S_ROUTE;
            end
         end
         S_ROUTE:    state_in = stat.first ? S_FB_MUL : S_READ_OLD;
         S_READ_OLD: begin
            cmd.op   = OP_READ_OLD;
            state_in = S_CAPTURE;
         end
         S_CAPTURE: begin
            cmd.op   = OP_CAPTURE;
            state_in = S_STEP;
         end
         S_STEP: begin
            cmd.op   = OP_STEP;
            state_in = stat.at_newest ? S_CHECK : S_ACCUM;
         end
         S_ACCUM: begin
            cmd.op   = OP_ACCUM;
            state_in = S_STEP;
         end
         S_CHECK:    state_in = stat.est_ok ? S_MUL_BUSY : S_FB_MUL;
         S_MUL_BUSY: begin
            cmd.op   = OP_MUL_BUSY;
            state_in = S_MUL_SPAN;
         end
         S_MUL_SPAN: begin
            cmd.op   = OP_MUL_SPAN;
            state_in = S_MUL_LH;
         end
         S_MUL_LH: begin
            cmd.op   = OP_MUL_LH;
            state_in = S_MUL_NUM;
         end
         S_MUL_NUM: begin
            cmd.op   = OP_MUL_NUM;
            state_in = S_MUL_DEN;
         end
         S_MUL_DEN: begin
            cmd.op   = OP_MUL_DEN;
            state_in = S_SHARE;
         end
         S_SHARE: begin
            if (stat.share_sat) begin
               cmd.op   = OP_SHARE_ONE;
               state_in = S_RATE;
            end else begin
               cmd.op   = OP_DIV_SHARE;
               state_in = S_SHARE_WAIT;
            end
         end
         S_SHARE_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_TAKE_SHARE;
               state_in = S_RATE;
            end
         end
         S_RATE: begin
            if (stat.rate_sat) begin
               cmd.op   = OP_RATE_ONE;
               state_in = S_WORK;
            end else begin
               cmd.op   = OP_DIV_RATE;
               state_in = S_RATE_WAIT;
            end
         end
         S_RATE_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_TAKE_RATE;
               state_in = S_WORK;
            end
         end
         S_WORK: begin
            if (stat.work_per) begin
               cmd.op   = OP_WORK_PER;
               state_in = S_DONE;
            end else begin
               cmd.op   = OP_MUL_WORK;
               state_in = S_WORK_DIV;
            end
         end
         S_WORK_DIV: begin
            cmd.op   = OP_DIV_WORK;
            state_in = S_WORK_WAIT;
         end
         S_WORK_WAIT: begin
            if (!stat.div_busy) begin
               cmd.op   = OP_TAKE_WORK;
               state_in = S_DONE;
            end
         end
         S_FB_MUL: begin
            cmd.op   = OP_MUL_FB;
            state_in = S_FB_WORK;
         end
         S_FB_WORK: begin
            cmd.op   = OP_FB_WORK;
            state_in = S_FB_SHARE;
         end
         S_FB_SHARE: begin
            cmd.op   = OP_FB_SHARE;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.op   = OP_PUSH;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/dcct_dp.sv
// Datapath of the duty-cycle throttle: sample ring, window sum, shared
// multiplier, restoring divider, config registers and result register.
// Depends on dcct_pkg; driven by dcct_ctrl.
`default_nettype none
module dcct_dp #(
   parameter int WINDOW_DEPTH = dcct_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   input  dcct_pkg::cmd_type            cmd,
   output dcct_pkg::status_type         stat,
   input  wire [dcct_pkg::REQ_W-1:0]    req_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   output logic [dcct_pkg::RSP_W-1:0]   rsp_tdata,
   input  wire                          csr_we,
   input  wire [dcct_pkg::CSR_A_W-1:0]  csr_addr,
   input  wire [dcct_pkg::WORK_W-1:0]   csr_wdata
);
   import dcct_pkg::*;

   localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int ENT_W = TIME_W + TICK_W + WORK_W;
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

   // ring entry: {worked, ticks, time}
   logic [ENT_W-1:0] ring [WINDOW_DEPTH];
   logic [ENT_W-1:0] rd_ff;
   logic [IDX_W-1:0] rd_addr;

   logic [LIM_W-1:0]  limit_ff, limit_in;
   logic [WORK_W-1:0] period_ff, period_in;
   logic [HZ_W-1:0]   hz_ff, hz_in;

   logic [IDX_W-1:0] newest_ff, newest_in, oldest_ff, oldest_in, ptr_ff, ptr_in;
   logic             empty_ff, empty_in, first_ff, first_in;

   logic [TIME_W-1:0]  t_new_ff, t_new_in, dt_ff, dt_in;
   logic [TICK_W-1:0]  k_new_ff, k_new_in, used_ff, used_in;
   logic [SUM_W-1:0]   acc_ff, acc_in;
   logic [BUSY_W-1:0]  busy_ff, busy_in;
   logic [SPAN_W-1:0]  span_ff, span_in;
   logic [LH_W-1:0]    lh_ff, lh_in;
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [DEN_W-1:0]   den_ff, den_in;
   logic [WPROD_W-1:0] wprod_ff, wprod_in;

   logic [DVS_W-1:0]   rem_ff, rem_in, dvs_ff, dvs_in;
   logic [QUO_W-1:0]   low_ff, low_in, quo_ff, quo_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               run_ff, run_in;

   logic [WORK_W-1:0]  work_ff, work_in;
   logic [Q16_W-1:0]   share_ff, share_in, rate_ff, rate_in;
   logic               valid_ff, valid_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   logic [LIM_W-1:0]   lim;
   logic [HZ_W-1:0]    hz;
   logic [IDX_W-1:0]   newest_inc, oldest_inc, ptr_inc;
   logic               load_first;
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_p;
   logic [DVS_W:0]     trial, diff;
   logic               trial_ge;
   logic [DVD_W-1:0]   dvd_sel;
   logic [DVS_W-1:0]   dvs_sel;
   logic [WORK_W-1:0]  sleep;

   assign lim        = (limit_ff > PCT_FULL) ? PCT_FULL : limit_ff;
   assign hz         = (hz_ff == '0) ? HZ_W'(1) : hz_ff;
   assign newest_inc = (newest_ff == IDX_LAST) ? '0 : newest_ff + IDX_W'(1);
   assign oldest_inc = (oldest_ff == IDX_LAST) ? '0 : oldest_ff + IDX_W'(1);
   assign ptr_inc    = (ptr_ff == IDX_LAST) ? '0 : ptr_ff + IDX_W'(1);
   assign load_first = empty_ff | req_tdata[TIME_W+TICK_W+WORK_W];

   // shared multiplier, one product per state
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_MUL_BUSY: begin
            mul_a = MUL_A_W'(used_ff);
            mul_b = US_PER_S;
         end
         OP_MUL_SPAN: begin
            mul_a = dt_ff;
            mul_b = MUL_B_W'(hz);
         end
         OP_MUL_LH: begin
            mul_a = MUL_A_W'(lim);
            mul_b = MUL_B_W'(hz);
         end
         OP_MUL_NUM: begin
            mul_a = MUL_A_W'(acc_ff);
            mul_b = MUL_B_W'(lh_ff);
         end
         OP_MUL_DEN: begin
            mul_a = MUL_A_W'(used_ff);
            mul_b = US_PER_S_PCT;
         end
         OP_MUL_WORK: begin
            mul_a = MUL_A_W'(num_ff);
            mul_b = MUL_B_W'(period_ff);
         end
         OP_MUL_FB: begin
            mul_a = MUL_A_W'(period_ff);
            mul_b = MUL_B_W'(lim);
         end
         // divide by 100 through the reciprocal; period times limit is below 2^27
         OP_FB_WORK: begin
            mul_a = MUL_A_W'(wprod_ff);
            mul_b = RECIP_PCT;
         end
         OP_FB_SHARE: begin
            mul_a = MUL_A_W'({lim, 16'd0});
            mul_b = RECIP_PCT;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_p = MUL_P_W'(mul_a) * MUL_P_W'(mul_b);

   // divider operand select
   always_comb begin
      dvd_sel = '0;
      dvs_sel = '0;
      case (cmd.op)
         OP_DIV_SHARE: begin
            dvd_sel = {busy_ff, 16'd0};
            dvs_sel = span_ff;
         end
         OP_DIV_RATE: begin
            dvd_sel = DVD_W'({acc_ff, 16'd0});
            dvs_sel = DVS_W'(dt_ff);
         end
         OP_DIV_WORK: begin
            dvd_sel = DVD_W'(wprod_ff);
            dvs_sel = DVS_W'(den_ff);
         end
         default:         dvd_sel = '0;
      endcase
   end

   // one quotient bit per cycle
   assign trial    = {rem_ff, low_ff[QUO_W-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign trial_ge = trial >= {1'b0, dvs_ff};
   assign sleep    = period_ff - work_ff;

   always_comb begin
      rd_addr = oldest_ff;
      if (cmd.op == OP_STEP) begin
         rd_addr = ptr_inc;
      end
   end

   always_comb begin
      limit_in = limit_ff;
      period_in = period_ff;
      hz_in = hz_ff;
      newest_in = newest_ff;
      oldest_in = oldest_ff;
      ptr_in = ptr_ff;
      empty_in = empty_ff;
      first_in = first_ff;
      t_new_in = t_new_ff;
      k_new_in = k_new_ff;
      dt_in = dt_ff;
      used_in = used_ff;
      acc_in = acc_ff;
      busy_in = busy_ff;
      span_in = span_ff;
      lh_in = lh_ff;
      num_in = num_ff;
      den_in = den_ff;
      wprod_in = wprod_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      low_in = low_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      work_in = work_ff;
      share_in = share_ff;
      rate_in = rate_ff;
      valid_in = valid_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_addr)
            CSR_LIMIT:     limit_in  = csr_wdata[LIM_W-1:0];
            CSR_PERIOD:    period_in = csr_wdata;
            CSR_TICK_RATE: hz_in     = csr_wdata[HZ_W-1:0];
            default:       limit_in  = limit_ff;
         endcase
      end

      if (run_ff) begin
         rem_in = trial_ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], trial_ge};
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         run_in = (cnt_ff != CNT_W'(1));
      end

      case (cmd.op)
         OP_LOAD: begin
            first_in  = load_first;
            newest_in = load_first ? '0 : newest_inc;
            oldest_in = load_first ? '0 : oldest_ff;
            empty_in  = 1'b0;
            t_new_in  = req_tdata[TIME_W-1:0];
            k_new_in  = req_tdata[TIME_W+TICK_W-1:TIME_W];
         end
         OP_READ_OLD: begin
            ptr_in = oldest_ff;
            acc_in = '0;
         end
         OP_CAPTURE: begin
            dt_in   = t_new_ff - rd_ff[TIME_W-1:0];
            used_in = k_new_ff - rd_ff[TIME_W+TICK_W-1:TIME_W];
         end
         OP_STEP: begin
            if (ptr_ff != newest_ff) begin
               ptr_in = ptr_inc;
            end else if (newest_inc == oldest_ff) begin
               // window full: drop the oldest sample
               oldest_in = oldest_inc;
            end
         end
         OP_ACCUM: acc_in = acc_ff + SUM_W'(rd_ff[ENT_W-1:TIME_W+TICK_W]);
         OP_MUL_BUSY: begin
            busy_in  = mul_p[BUSY_W-1:0];
            valid_in = 1'b1;
         end
         OP_MUL_SPAN: span_in = mul_p[SPAN_W-1:0];
         OP_MUL_LH:   lh_in = mul_p[LH_W-1:0];
         OP_MUL_NUM:  num_in = mul_p[NUM_W-1:0];
         OP_MUL_DEN:  den_in = mul_p[DEN_W-1:0];
         OP_MUL_WORK: wprod_in = mul_p[WPROD_W-1:0];
         OP_MUL_FB: begin
            wprod_in = mul_p[WPROD_W-1:0];
            valid_in = 1'b0;
         end
         OP_FB_WORK: work_in = mul_p[RECIP_SH+WORK_W-1:RECIP_SH];
         OP_FB_SHARE: begin
            share_in = mul_p[RECIP_SH+Q16_W-1:RECIP_SH];
            rate_in  = mul_p[RECIP_SH+Q16_W-1:RECIP_SH];
         end
         OP_DIV_SHARE, OP_DIV_RATE, OP_DIV_WORK: begin
            // quotient fits 21 bits, so the upper dividend part is below the divisor
            rem_in = DVS_W'(dvd_sel[DVD_W-1:QUO_W]);
            low_in = dvd_sel[QUO_W-1:0];
            dvs_in = dvs_sel;
            quo_in = '0;
            cnt_in = CNT_W'(QUO_W);
            run_in = 1'b1;
         end
         OP_TAKE_SHARE: share_in = quo_ff[Q16_W-1:0];
         OP_TAKE_RATE:  rate_in = quo_ff[Q16_W-1:0];
         OP_TAKE_WORK:  work_in = quo_ff[WORK_W-1:0];
         OP_SHARE_ONE: share_in = Q16_ONE;
         OP_RATE_ONE:  rate_in = Q16_ONE;
         OP_WORK_PER:  work_in = period_ff;
         OP_PUSH: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = RSP_W'({valid_ff, rate_ff, share_ff, sleep, work_ff});
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_LOAD) begin
         ring[newest_in] <= req_tdata[ENT_W-1:0];
      end
      rd_ff <= ring[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RST;
         period_ff    <= PERIOD_RST;
         hz_ff        <= HZ_RST;
         newest_ff    <= '0;
         oldest_ff    <= '0;
         empty_ff     <= 1'b1;
         run_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         period_ff    <= period_in;
         hz_ff        <= hz_in;
         newest_ff    <= newest_in;
         oldest_ff    <= oldest_in;
         empty_ff     <= empty_in;
         run_ff       <= run_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff      <= ptr_in;
      first_ff    <= first_in;
      t_new_ff    <= t_new_in;
      k_new_ff    <= k_new_in;
      dt_ff       <= dt_in;
      used_ff     <= used_in;
      acc_ff      <= acc_in;
      busy_ff     <= busy_in;
      span_ff     <= span_in;
      lh_ff       <= lh_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      wprod_ff    <= wprod_in;
      rem_ff      <= rem_in;
      dvs_ff      <= dvs_in;
      low_ff      <= low_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      work_ff     <= work_in;
      share_ff    <= share_in;
      rate_ff     <= rate_in;
      valid_ff    <= valid_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign stat.first     = first_ff;
   assign stat.at_newest = (ptr_ff == newest_ff);
   assign stat.est_ok    = (dt_ff != '0) && (acc_ff != '0);
   assign stat.share_sat = SPAN_W'(busy_ff) >= span_ff;
   assign stat.rate_sat  = TIME_W'(acc_ff) >= dt_ff;
   assign stat.work_per  = (used_ff == '0) || (DEN_W'(num_ff) >= den_ff);
   assign stat.div_busy  = run_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

>>> rtl/duty_cycle_cpu_throttle.sv
// Top level of the windowed duty-cycle throttle: sequencer plus datapath.
// Depends on dcct_pkg, dcct_ctrl and dcct_dp.
//
//   channel  dir  fields
//   req_*    in   samples: time, busy ticks, run time, restart
//   rsp_*    out  run/sleep slices, busy share, working rate, estimate flag
//   csr_*    in   register writes: limit, period, tick rate
//
// One sample at a time. A first sample goes straight to the fallback. Otherwise the window
// walk reads the oldest entry and steps to the newest, summing the run times; a fallback
// or an estimate follows, the estimate with five or six products and up to three
// restoring divider passes. Synchronous reset clears the window and loads the
// register defaults. A finished result waits in the output register while the
// next sample is taken; that sample's result stalls until the register is free.
`default_nettype none
module duty_cycle_cpu_throttle #(
   parameter int WINDOW_DEPTH = dcct_pkg::WINDOW_DEPTH_DEF
) (
   input  wire                          clock,
   input  wire                          reset,
   // [47:0] sample_time_us, [79:48] busy_ticks, [99:80] worked_us, [100] restart
   input  wire [dcct_pkg::REQ_W-1:0]    req_tdata,
   input  wire                          req_tvalid,
   output logic                         req_tready,
   // [19:0] work_us, [39:20] sleep_us, [56:40] cpu_share_q16,
   // [73:57] working_rate_q16, [74] estimate_valid
   output logic [dcct_pkg::RSP_W-1:0]   rsp_tdata,
   output logic                         rsp_tvalid,
   input  wire                          rsp_tready,
   input  wire                          csr_we,
   input  wire [dcct_pkg::CSR_A_W-1:0]  csr_addr,
   input  wire [dcct_pkg::WORK_W-1:0]   csr_wdata
);
   import dcct_pkg::*;

   cmd_type    cmd;
   status_type stat;

   dcct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   dcct_dp #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

endmodule
`default_nettype wire
